>>> design/text_console_cursor_engine_assert.svh
// Assertion macros used by the checker file of the cursor engine.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// Next-cycle implication, switched off while reset is held.
`define TCCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cursor engine assertion failed");

// Next-cycle implication that is also checked during reset.
`define TCCE_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cursor engine assertion failed");

`endif

>>> design/tcce_pkg.sv
package tcce_pkg;

  // Largest accepted glyph magnification.
  localparam int unsigned MAX_SCALE = 3;
  // Widest cell the two-bit scale register can describe.
  localparam int unsigned CELL_W_MAX = 24;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Operation codes on the input channel.
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_HOME = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_IDX_SCALE = 1'b0;
  localparam logic CFG_IDX_WIDTH = 1'b1;

  // Reset values.
  localparam logic [1:0]  SCALE_RST  = 2'd1;
  localparam logic [11:0] WIDTH_RST  = 12'd1024;
  localparam logic [15:0] CUR_Y_RST  = 16'd16;
  localparam logic [15:0] Y_MAX      = 16'hFFFF;

  // Kind of the item held in the datapath.
  typedef enum logic [2:0] {
    KIND_HOME,
    KIND_NEWLINE,
    KIND_TAB,
    KIND_BACKSPACE,
    KIND_PRINT
  } kind_t;

  // Datapath step issued by the controller.
  typedef enum logic [2:0] {
    DP_NONE,
    DP_HOME,
    DP_NEWLINE,
    DP_SPACE_ADV,
    DP_CHAR_ADV,
    DP_BACKSPACE
  } dp_op_t;

  typedef struct packed {
    logic   load_item;
    dp_op_t op;
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  tab_fits;
    logic  out_free;
  } dp_stat_t;

  // Residue modulo three of a nine-bit value: base-four digits are summed,
  // since four leaves a remainder of one, then the small sum is reduced.
  function automatic logic [1:0] mod3_9(input logic [8:0] v);
    logic [3:0] s;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]) + 4'(v[8]);
    if (s >= 4'd9) s = s - 4'd9;
    if (s >= 4'd6) s = s - 4'd6;
    if (s >= 4'd3) s = s - 4'd3;
    return s[1:0];
  endfunction

endpackage

>>> design/tcce_dpath.sv
module tcce_dpath
  import tcce_pkg::*;
#(
  parameter int unsigned TAB_CELLS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [63:0] out_tdata,
  output logic        out_tlast,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat
);

  localparam int unsigned SUM_W = $clog2(4095 + TAB_CELLS * CELL_W_MAX + 1);

  logic [1:0]  scale_r;
  logic [11:0] swidth_r;
  logic [11:0] cur_x_r;
  logic [15:0] cur_y_r;
  logic        item_op_r;
  logic [7:0]  item_char_r;
  logic [23:0] item_color_r;
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic [11:0] out_x_r;
  logic [15:0] out_y_r;
  logic [23:0] out_color_r;
  logic        out_last_r;

  logic [4:0]       cell_w;
  logic [5:0]       cell_h;
  logic [12:0]      adv_sum;
  logic [16:0]      nl_sum;
  logic [15:0]      nl_y;
  logic [11:0]      adv_x;
  logic [15:0]      adv_y;
  logic [SUM_W-1:0] tab_span;
  logic [SUM_W-1:0] tab_sum;
  logic [11:0]      wrap_x;
  logic [8:0]       wrap_q;
  logic [1:0]       wrap_m;
  logic [11:0]      wrap_col;
  logic [11:0]      bs_x;
  logic [15:0]      bs_y;
  logic             emit;
  logic [1:0]       scale_wr;

  // Cell geometry follows the scale register.
  assign cell_w = {scale_r, 3'b000};
  assign cell_h = {scale_r, 4'b0000};

  // New line: column zero, row below, saturating at the bottom.
  assign nl_sum = {1'b0, cur_y_r} + 17'(cell_h);
  assign nl_y   = nl_sum[16] ? Y_MAX : nl_sum[15:0];

  // Advance by one cell or wrap onto a new line.
  assign adv_sum = {1'b0, cur_x_r} + 13'(cell_w);
  always_comb begin
    if (adv_sum >= {1'b0, swidth_r}) begin
      adv_x = '0;
      adv_y = nl_y;
    end else begin
      adv_x = adv_sum[11:0];
      adv_y = cur_y_r;
    end
  end

  // A tab fits when all its cells end before the screen width.
  assign tab_span = SUM_W'(TAB_CELLS) * SUM_W'(cell_w);
  assign tab_sum  = SUM_W'(cur_x_r) + tab_span;

  // Last cell-aligned column of a row: floor to a multiple of the cell width.
  // The low three bits always clear, so only the eighth-pixel count needs its
  // residue modulo the scale.
  assign wrap_x = swidth_r - 12'(cell_w);
  assign wrap_q = wrap_x[11:3];
  always_comb begin
    unique case (scale_r)
      2'd2:    wrap_m = {1'b0, wrap_q[0]};
      2'd3:    wrap_m = mod3_9(wrap_q);
      default: wrap_m = 2'd0;
    endcase
  end
  assign wrap_col = {wrap_q - 9'(wrap_m), 3'b000};

  // Backspace target position.
  always_comb begin
    bs_x = cur_x_r;
    bs_y = cur_y_r;
    if (cur_x_r < 12'(cell_w)) begin
      if (cur_y_r >= 16'(cell_h)) begin
        bs_y = cur_y_r - 16'(cell_h);
        bs_x = (swidth_r < 12'(cell_w)) ? 12'd0 : wrap_col;
      end
    end else begin
      bs_x = cur_x_r - 12'(cell_w);
    end
  end

  // Status towards the controller.
  always_comb begin
    stat.tab_fits = (tab_sum < SUM_W'(swidth_r));
    stat.out_free = !out_valid_r || out_tready;
    if (item_op_r == OP_HOME) begin
      stat.kind = KIND_HOME;
    end else begin
      unique case (item_char_r)
        CH_NEWLINE:   stat.kind = KIND_NEWLINE;
        CH_TAB:       stat.kind = KIND_TAB;
        CH_BACKSPACE: stat.kind = KIND_BACKSPACE;
        default:      stat.kind = KIND_PRINT;
      endcase
    end
  end

  assign emit     = (cmd.op == DP_SPACE_ADV) || (cmd.op == DP_CHAR_ADV) ||
                    (cmd.op == DP_BACKSPACE);
  assign scale_wr = cfg_data[1:0];

  // Configuration, cursor and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= SCALE_RST;
      swidth_r    <= WIDTH_RST;
      cur_x_r     <= '0;
      cur_y_r     <= CUR_Y_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_IDX_SCALE) begin
          if (scale_wr != 2'd0 && 32'(scale_wr) <= MAX_SCALE) begin
            scale_r <= scale_wr;
          end
        end else begin
          swidth_r <= cfg_data;
        end
      end
      unique case (cmd.op)
        DP_HOME: begin
          cur_x_r <= '0;
          cur_y_r <= '0;
        end
        DP_NEWLINE: begin
          cur_x_r <= '0;
          cur_y_r <= nl_y;
        end
        DP_SPACE_ADV, DP_CHAR_ADV: begin
          cur_x_r <= adv_x;
          cur_y_r <= adv_y;
        end
        DP_BACKSPACE: begin
          cur_x_r <= bs_x;
          cur_y_r <= bs_y;
        end
        default: ;
      endcase
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item capture and output payload.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op_r    <= in_tuser;
      item_char_r  <= in_tdata[7:0];
      item_color_r <= in_tdata[31:8];
    end
    if (emit) begin
      out_color_r <= item_color_r;
      out_last_r  <= cmd.last;
      if (cmd.op == DP_BACKSPACE) begin
        out_char_r <= CH_SPACE;
        out_x_r    <= bs_x;
        out_y_r    <= bs_y;
      end else begin
        out_char_r <= (cmd.op == DP_SPACE_ADV) ? CH_SPACE : item_char_r;
        out_x_r    <= cur_x_r;
        out_y_r    <= cur_y_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_color_r, out_y_r, out_x_r, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

>>> design/tcce_ctrl.sv
module tcce_ctrl
  import tcce_pkg::*;
#(
  parameter int unsigned TAB_CELLS = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int unsigned CNT_W = (TAB_CELLS > 1) ? $clog2(TAB_CELLS) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done;
  logic             tab_last;
  logic             accept;

  assign tab_last = (cnt_r == CNT_W'(TAB_CELLS - 1));

  // Step selection for the item being worked on.
  always_comb begin
    cmd.op   = DP_NONE;
    cmd.last = 1'b0;
    done     = 1'b0;
    if (state_r == ST_WORK) begin
      unique case (stat.kind)
        KIND_HOME: begin
          cmd.op = DP_HOME;
          done   = 1'b1;
        end
        KIND_NEWLINE: begin
          cmd.op = DP_NEWLINE;
          done   = 1'b1;
        end
        KIND_TAB: begin
          if (cnt_r == '0 && !stat.tab_fits) begin
            cmd.op = DP_NEWLINE;
            done   = 1'b1;
          end else if (stat.out_free) begin
            cmd.op   = DP_SPACE_ADV;
            cmd.last = tab_last;
            done     = tab_last;
          end
        end
        KIND_BACKSPACE: begin
          if (stat.out_free) begin
            cmd.op   = DP_BACKSPACE;
            cmd.last = 1'b1;
            done     = 1'b1;
          end
        end
        default: begin
          if (stat.out_free) begin
            cmd.op   = DP_CHAR_ADV;
            cmd.last = 1'b1;
            done     = 1'b1;
          end
        end
      endcase
    end
    cmd.load_item = in_tvalid && ((state_r == ST_IDLE) || done);
  end

  // A new item may enter in the cycle that finishes the previous one.
  assign in_tready = (state_r == ST_IDLE) || done;
  assign accept    = in_tvalid && in_tready;

  // State and tab cell counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      if (accept) begin
        state_r <= ST_WORK;
        cnt_r   <= '0;
      end else if (done) begin
        state_r <= ST_IDLE;
      end else if (cmd.op == DP_SPACE_ADV) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end
    end
  end

endmodule

>>> design/text_console_cursor_engine.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_tvalid / in_tready   | tdata: char, colour; tuser: operation
// out     | output    | out_tvalid / out_tready | tdata: char, x, y, colour; tlast
// cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A printable character or backspace gives one result; a tab that fits gives
// TAB_CELLS results, one per space, paced by the single output register.
// Newline, home and a tab that does not fit give no result.
// The next item is taken in the cycle that finishes the current one.
// Reset (rst_n low at a clock edge) restores scale 1, width 1024, cursor 0,16.
// A stall on the output holds the current item until its results drain.
module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int unsigned TAB_CELLS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] char_code, [31:8] pixel_color
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] cell_char, [19:8] cell_x, [35:20] cell_y, [59:36] cell_color, zero fill
  output logic [63:0] out_tdata,
  output logic        out_tlast,  // is_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  tcce_ctrl #(
    .TAB_CELLS(TAB_CELLS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcce_dpath #(
    .TAB_CELLS(TAB_CELLS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> design/tcce_checker.sv
`include "text_console_cursor_engine_assert.svh"

module tcce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  // Reset leaves no result on the output.
  `TCCE_ASSERT_NEXT_ALWAYS(a_reset_clears_out, !rst_n, !out_tvalid)

  // A stalled result keeps its payload.
  `TCCE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // Once a result that is not the last of its item is taken, the next one of
  // the same item is already in the output register.
  `TCCE_ASSERT_NEXT(a_run_continues, out_tvalid && out_tready && !out_tlast, out_tvalid)

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

>>> tb/tb_text_console_cursor_engine.sv
module tb_text_console_cursor_engine;
  import tcce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAB_CELLS = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 40;
  localparam int SCROLL_ITEMS = 124;

  // One character-cell write as it leaves the block.
  typedef struct packed {
    logic [7:0]  glyph;
    logic [11:0] x;
    logic [15:0] y;
    logic [23:0] colour;
    logic        last;
  } cell_write_t;

  // Tracks the cursor and the scaling registers, and holds the cell writes
  // that accepted items have yet to produce.
  class cell_write_tracker;
    logic [1:0]  scale;
    logic [11:0] screen_w;
    logic [11:0] cur_x;
    logic [15:0] cur_y;
    cell_write_t pending_cells[$];
    int          errors;

    function new();
      scale    = SCALE_RST;
      screen_w = WIDTH_RST;
      cur_x    = '0;
      cur_y    = CUR_Y_RST;
      errors   = 0;
    endfunction

    // A scale of zero is refused; only the low two bits of the data count.
    function void write_reg(logic idx, logic [11:0] data);
      if (idx == CFG_IDX_SCALE) begin
        if (data[1:0] >= 1 && data[1:0] <= MAX_SCALE) scale = data[1:0];
      end else begin
        screen_w = data;
      end
    endfunction

    // Start of the next row; the row position saturates rather than wrapping.
    function void line_feed();
      int unsigned y;
      y = cur_y + 16 * scale;
      cur_y = (y > Y_MAX) ? Y_MAX : y[15:0];
      cur_x = '0;
    endfunction

    function void step_right();
      int unsigned cw;
      cw = 8 * scale;
      if (cur_x + cw >= screen_w) line_feed();
      else cur_x = 12'(cur_x + cw);
    endfunction

    function void queue_cell(logic [7:0] glyph, logic [23:0] colour, logic last);
      cell_write_t c;
      c.glyph  = glyph;
      c.x      = cur_x;
      c.y      = cur_y;
      c.colour = colour;
      c.last   = last;
      pending_cells.push_back(c);
    endfunction

    // Updates the cursor for one accepted input transaction and queues the
    // cell writes that it causes.
    function void note_item(logic op, logic [7:0] glyph, logic [23:0] colour);
      int unsigned cw;
      int unsigned rows;
      int unsigned span;
      cw   = 8 * scale;
      rows = 16 * scale;
      if (op == OP_HOME) begin
        cur_x = '0;
        cur_y = '0;
        return;
      end
      case (glyph)
        CH_NEWLINE: line_feed();
        CH_TAB: begin
          if (cur_x + TAB_CELLS * cw >= screen_w) begin
            line_feed();
          end else begin
            for (int i = 0; i < TAB_CELLS; i++) begin
              queue_cell(CH_SPACE, colour, i == TAB_CELLS - 1);
              step_right();
            end
          end
        end
        CH_BACKSPACE: begin
          // At column 0 go up a row to the last whole cell, unless already on
          // the top row, where the cursor stays put.
          if (cur_x < cw) begin
            if (cur_y >= rows) begin
              cur_y = 16'(cur_y - rows);
              if (screen_w < cw) begin
                cur_x = '0;
              end else begin
                span  = screen_w - cw;
                cur_x = 12'(span - span % cw);
              end
            end
          end else begin
            cur_x = 12'(cur_x - cw);
          end
          queue_cell(CH_SPACE, colour, 1'b1);
        end
        default: begin
          queue_cell(glyph, colour, 1'b1);
          step_right();
        end
      endcase
    endfunction

    function void compare(string what, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: cell %s mismatch: expected 0x%0h, actual 0x%0h",
                 $time, what, want, got);
      end
    endfunction

    // Checks one output transaction against the oldest pending cell write.
    function void check_cell(logic [63:0] data, logic tlast);
      cell_write_t want;
      if (pending_cells.size() == 0) begin
        errors++;
        $display("%0t: cell write with none pending: expected nothing, actual 0x%0h last %0b",
                 $time, data, tlast);
        return;
      end
      want = pending_cells.pop_front();
      compare("glyph", 64'(want.glyph), 64'(data[7:0]));
      compare("x", 64'(want.x), 64'(data[19:8]));
      compare("y", 64'(want.y), 64'(data[35:20]));
      compare("colour", 64'(want.colour), 64'(data[59:36]));
      compare("padding", 64'(0), 64'(data[63:60]));
      compare("last flag", 64'(want.last), 64'(tlast));
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [11:0] cfg_data = '0;

  cell_write_tracker tracker = new();
  bit send_idle_on = 1'b0;

  // Register settings for the random phases; three of the values are redrawn at run time.
  logic [1:0]  phase_scale [PHASE_COUNT] = '{2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1};
  logic [11:0] phase_width [PHASE_COUNT] =
    '{12'd4095, 12'd100, 12'd7, 12'd8, 12'd0, 12'd0, 12'd0, 12'd1024};

  text_console_cursor_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offers one input transaction after a random gap. Valid is left high on
  // acceptance so that a back-to-back item needs no second assignment.
  task automatic send_item(input logic op, input logic [7:0] glyph, input logic [23:0] colour);
    int gap;
    if ($urandom_range(0, 15) == 0) send_idle_on = !send_idle_on;
    gap = send_idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {colour, glyph};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    tracker.note_item(op, glyph, colour);
  endtask

  // Weighted draw over home, newline, tab, backspace and any byte at all.
  task automatic send_random_item(input int home_pct, input int nl_pct,
                                  input int tab_pct, input int bs_pct);
    int          pick;
    logic [7:0]  glyph;
    logic [23:0] colour;
    pick   = $urandom_range(0, 99);
    glyph  = 8'($urandom);
    colour = 24'($urandom);
    if (pick < home_pct) send_item(OP_HOME, glyph, colour);
    else if (pick < home_pct + nl_pct) send_item(OP_PUT, CH_NEWLINE, colour);
    else if (pick < home_pct + nl_pct + tab_pct) send_item(OP_PUT, CH_TAB, colour);
    else if (pick < home_pct + nl_pct + tab_pct + bs_pct)
      send_item(OP_PUT, CH_BACKSPACE, colour);
    else send_item(OP_PUT, glyph, colour);
  endtask

  // Waits until every cell write has arrived and the block has had time to
  // finish any item that writes nothing.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the scale and then the width; the unused scale bits are random.
  task automatic program_registers(input logic [1:0] scale, input logic [11:0] width);
    logic [11:0] scale_word;
    scale_word = {10'($urandom), scale};
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_SCALE;
    cfg_data  <= scale_word;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(CFG_IDX_SCALE, scale_word);
    cfg_index <= CFG_IDX_WIDTH;
    cfg_data  <= width;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(CFG_IDX_WIDTH, width);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls per transaction, with stretches of none.
  initial begin : drain_cells
    int stall;
    bit idle_on;
    idle_on = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
      stall = idle_on ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_cell(out_tdata, out_tlast);
    end
  end

  initial begin : stimulus
    int p;
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset settings: field extremes, every kind of
    // character, backspace wrapping to the previous row, and backspace on the
    // top row at column 0.
    send_item(OP_PUT, 8'h41, 24'h000000);
    send_item(OP_PUT, 8'hFF, 24'hFFFFFF);
    send_item(OP_PUT, 8'h00, 24'hAAAAAA);
    send_item(OP_PUT, CH_TAB, 24'h555555);
    send_item(OP_PUT, CH_BACKSPACE, 24'h123456);
    send_item(OP_PUT, CH_NEWLINE, 24'hFFFFFF);
    send_item(OP_PUT, CH_BACKSPACE, 24'h0F0F0F);
    send_item(OP_PUT, 8'h7F, 24'hF0F0F0);
    send_item(OP_PUT, CH_TAB, 24'h00FF00);
    send_item(OP_HOME, CH_TAB, 24'hFFFFFF);
    send_item(OP_PUT, CH_BACKSPACE, 24'h800001);
    send_item(OP_PUT, 8'h80, 24'h7FFFFE);
    send_item(OP_HOME, 8'hFF, 24'h000000);
    send_item(OP_PUT, CH_TAB, 24'hC0FFEE);
    send_item(OP_PUT, CH_NEWLINE, 24'h000000);
    send_item(OP_PUT, 8'h20, 24'h010203);

    // Random phases over several register settings, the extremes among them.
    phase_scale[6] = 2'($urandom_range(0, 3));
    phase_width[5] = 12'($urandom);
    phase_width[6] = 12'($urandom);
    for (p = 0; p < PHASE_COUNT; p++) begin
      settle();
      program_registers(phase_scale[p], phase_width[p]);
      for (n = 0; n < PHASE_ITEMS; n++) send_random_item(6, 12, 15, 15);
    end

    // Scroll on a narrow screen at the largest scale, so that nearly every
    // item moves down a row.
    settle();
    program_registers(2'd3, 12'd20);
    for (n = 0; n < SCROLL_ITEMS; n++) send_random_item(0, 45, 10, 3);

    in_tvalid <= 1'b0;
    while (tracker.pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb_text_console_cursor_engine: PASS");
    end else begin
      $display("tb_text_console_cursor_engine: FAIL");
    end
    $finish;
  end

  // Generous limit on the whole run.
  initial begin : watchdog
    #3000000;
    $display("tb_text_console_cursor_engine: FAIL");
    $finish;
  end

endmodule
